@@ design/gfs_pkg.sv @@
// Shared constants, codes and types for the GF(2) syndrome checker.
package gfs_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int VECTOR_BITS_DEF = 64;
	localparam int WORD_W          = 64;
	localparam int ROW_IDX_W       = 6;
	localparam int CFG_W           = 7;
	localparam int CFG_IDX_W       = 2;
	localparam int PART_W          = 8;
	localparam int PART_N          = WORD_W / PART_W;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_CHECK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_ROWS     = 2'd0,
		CFG_NUM_COLS     = 2'd1,
		CFG_COMPARE_BITS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] num_rows;
		logic [CFG_W-1:0] num_cols;
		logic [CFG_W-1:0] compare_bits;
	} cfg_t;

	typedef struct packed {
		logic                 en;
		logic [ROW_IDX_W-1:0] addr;
		logic [WORD_W-1:0]    data;
	} row_wr_t;

endpackage

@@ design/gfs_if.sv @@
// Channel interfaces: input words, result words and register writes.
interface gfs_req_if
	import gfs_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [ROW_IDX_W-1:0] row_index;
	logic [WORD_W-1:0]    row_bits;
	logic [WORD_W-1:0]    error_vector;
	logic [WORD_W-1:0]    target_syndrome;

	modport source (output valid, cmd, row_index, row_bits, error_vector, target_syndrome,
		input ready);
	modport sink (input valid, cmd, row_index, row_bits, error_vector, target_syndrome,
		output ready);
endinterface

interface gfs_rsp_if
	import gfs_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] syndrome;
	logic              matches_target;
	logic              syndrome_zero;
	logic              accepted;

	modport source (output valid, syndrome, matches_target, syndrome_zero, accepted,
		input ready);
	modport sink (input valid, syndrome, matches_target, syndrome_zero, accepted,
		output ready);
endinterface

interface gfs_cfg_if
	import gfs_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/gfs_row_store.sv @@
// Parity-check matrix row storage, one write port, all rows visible.
module gfs_row_store
	import gfs_pkg::*;
#(
	parameter int STORE_ROWS  = MAX_ROWS_DEF,
	parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
	input  logic                   clk,
	input  row_wr_t                wr,
	output logic [VECTOR_BITS-1:0] rows [STORE_ROWS]
);

	localparam int ROW_AW = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

	logic [VECTOR_BITS-1:0] rows_q [STORE_ROWS];

	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.addr) < 32'(STORE_ROWS))) begin
			rows_q[wr.addr[ROW_AW-1:0]] <= wr.data[VECTOR_BITS-1:0];
		end
	end

	assign rows = rows_q;

endmodule

@@ design/gfs_pipe.sv @@
// Four-stage syndrome pipeline: mask, partial parity, row parity, compare.
module gfs_pipe
	import gfs_pkg::*;
#(
	parameter int STORE_ROWS  = MAX_ROWS_DEF,
	parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   chk_valid,
	output logic                   chk_ready,
	input  logic [WORD_W-1:0]      error_vector,
	input  logic [WORD_W-1:0]      target_syndrome,
	input  cfg_t                   cfg,
	input  logic [VECTOR_BITS-1:0] rows [STORE_ROWS],
	gfs_rsp_if.source              rsp
);

	logic en1, en2, en3, en4;
	logic v1_s1, v2_s2, v3_s3;

	logic [VECTOR_BITS-1:0] e_s1;
	logic [WORD_W-1:0]      target_s1, rmask_s1, cmask_s1;

	logic [PART_N-1:0]      part_s2 [STORE_ROWS];
	logic [PART_N-1:0]      part_c  [STORE_ROWS];
	logic [WORD_W-1:0]      target_s2, rmask_s2, cmask_s2;

	logic [WORD_W-1:0]      syn_c;
	logic [WORD_W-1:0]      syn_s3, target_s3, rmask_s3, cmask_s3;

	logic [WORD_W-1:0]      e_mask_c, rmask_c, cmask_c;

	assign en4       = !rsp.valid || rsp.ready;
	assign en3       = !v3_s3 || en4;
	assign en2       = !v2_s2 || en3;
	assign en1       = !v1_s1 || en2;
	assign chk_ready = en1;

	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			e_mask_c[k] = 7'(k) < cfg.num_cols;
			rmask_c[k]  = 7'(k) < cfg.num_rows;
			cmask_c[k]  = 7'(k) < cfg.compare_bits;
		end
	end

	always_comb begin
		logic [WORD_W-1:0] prod;
		for (int i = 0; i < STORE_ROWS; i++) begin
			prod                    = '0;
			prod[VECTOR_BITS-1:0]   = rows[i] & e_s1;
			for (int g = 0; g < PART_N; g++) begin
				part_c[i][g] = ^prod[g*PART_W +: PART_W];
			end
		end
	end

	for (genvar i = 0; i < WORD_W; i++) begin : g_syn
		if (i < STORE_ROWS) begin : g_row
			assign syn_c[i] = (^part_s2[i]) & rmask_s2[i];
		end else begin : g_none
			assign syn_c[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (en1) v1_s1     <= chk_valid;
			if (en2) v2_s2     <= v1_s1;
			if (en3) v3_s3     <= v2_s2;
			if (en4) rsp.valid <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			e_s1      <= error_vector[VECTOR_BITS-1:0] & e_mask_c[VECTOR_BITS-1:0];
			target_s1 <= target_syndrome;
			rmask_s1  <= rmask_c;
			cmask_s1  <= cmask_c;
		end
		if (en2) begin
			part_s2   <= part_c;
			target_s2 <= target_s1;
			rmask_s2  <= rmask_s1;
			cmask_s2  <= cmask_s1;
		end
		if (en3) begin
			syn_s3    <= syn_c;
			target_s3 <= target_s2;
			rmask_s3  <= rmask_s2;
			cmask_s3  <= cmask_s2;
		end
		if (en4) begin
			rsp.syndrome       <= syn_s3;
			rsp.matches_target <= ((syn_s3 ^ target_s3) & cmask_s3) == '0;
			rsp.syndrome_zero  <= (syn_s3 & cmask_s3) == '0;
			rsp.accepted       <= (((syn_s3 ^ target_s3) & cmask_s3) == '0)
				|| ((syn_s3 & cmask_s3) == '0);
		end
	end

`ifndef SYNTHESIS
	a_adv_v2: assert property (@(posedge clk) disable iff (!arst_n)
		en2 |=> (v2_s2 == $past(v1_s1)))
		else $error("stage 2 valid does not follow stage 1");
	a_hold_v3: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && !en3) |=> (v3_s3 && $stable(syn_s3)))
		else $error("stalled stage 3 lost its word");
	a_rows_off: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 |-> ((syn_s3 & ~rmask_s3) == '0))
		else $error("syndrome bit set beyond rows in use");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && !en2) |-> !chk_ready)
		else $error("input taken while stage 1 is stalled");
`endif

endmodule

@@ design/gf2_syndrome_check.sv @@
// Top level of the GF(2) syndrome checker: registers, row store, pipeline.
//
//  channel | dir  | handshake   | word
//  --------+------+-------------+-------------------------------------------------
//  req     | in   | valid/ready | cmd, row_index, row_bits, error_vector, target
//  rsp     | out  | valid/ready | syndrome, matches_target, syndrome_zero, accepted
//  cfg     | in   | valid/ready | index, data (num_rows, num_cols, compare_bits)
//
//  One word per cycle while rsp is not stalled; a check word's result is registered
//  through the mask, partial parity, row parity and compare register stages.
//  A load word writes its row at the edge it is taken and gives no result.
//  Reset clears stage valids and sets all three registers to 64; rows stay
//  unknown until written. A stall on rsp holds each full stage in place, lets
//  empty stages fill, and drops req.ready once every stage holds a word;
//  cfg.ready is always high.
module gf2_syndrome_check
	import gfs_pkg::*;
#(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gfs_cfg_if.sink   cfg,
	gfs_req_if.sink   req,
	gfs_rsp_if.source rsp
);

	localparam int STORE_ROWS = (MAX_ROWS < WORD_W) ? MAX_ROWS : WORD_W;

	cfg_t                   cfg_q;
	row_wr_t                row_wr;
	logic                   chk_ready;
	logic [VECTOR_BITS-1:0] rows [STORE_ROWS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows     <= CFG_W'(WORD_W);
			cfg_q.num_cols     <= CFG_W'(WORD_W);
			cfg_q.compare_bits <= CFG_W'(WORD_W);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_NUM_ROWS:     cfg_q.num_rows     <= cfg.data;
				CFG_NUM_COLS:     cfg_q.num_cols     <= cfg.data;
				CFG_COMPARE_BITS: cfg_q.compare_bits <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req.ready   = chk_ready;
	assign row_wr.en   = req.valid && chk_ready && (req.cmd == CMD_LOAD);
	assign row_wr.addr = req.row_index;
	assign row_wr.data = req.row_bits;

	gfs_row_store #(
		.STORE_ROWS  (STORE_ROWS),
		.VECTOR_BITS (VECTOR_BITS)
	) u_store (
		.clk  (clk),
		.wr   (row_wr),
		.rows (rows)
	);

	gfs_pipe #(
		.STORE_ROWS  (STORE_ROWS),
		.VECTOR_BITS (VECTOR_BITS)
	) u_pipe (
		.clk             (clk),
		.arst_n          (arst_n),
		.chk_valid       (req.valid && (req.cmd == CMD_CHECK)),
		.chk_ready       (chk_ready),
		.error_vector    (req.error_vector),
		.target_syndrome (req.target_syndrome),
		.cfg             (cfg_q),
		.rows            (rows),
		.rsp             (rsp)
	);

endmodule

@@ verif/tb_gf2_syndrome_check.sv @@
// Testbench for gf2_syndrome_check: directed table, random words, syndrome scoreboard.
module tb_gf2_syndrome_check
	import gfs_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 250;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		logic [WORD_W-1:0] syn;
		logic              match;
		logic              zero;
		logic              acc;
	} syn_res_t;

	typedef enum {ENT_WORD, ENT_REG} ent_kind_t;

	typedef struct {
		ent_kind_t            kind;
		cmd_t                 cmd;
		logic [ROW_IDX_W-1:0] ridx;
		logic [WORD_W-1:0]    rbits;
		logic [WORD_W-1:0]    evec;
		logic [WORD_W-1:0]    tgt;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		bit                   known;
		syn_res_t             res;
	} dir_ent_t;

	logic clk = 1'b0;
	logic arst_n;

	gfs_cfg_if cfg_ch ();
	gfs_req_if req_ch ();
	gfs_rsp_if rsp_ch ();

	gf2_syndrome_check DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [WORD_W-1:0] h_mat [64];
	logic [CFG_W-1:0]  m_rows;
	logic [CFG_W-1:0]  m_cols;
	logic [CFG_W-1:0]  m_cmp;
	syn_res_t          pending_syndromes [$];
	int                mismatch_cnt = 0;
	bit                req_stall_en = 1'b0;
	bit                rsp_stall_en = 1'b0;

	always #4 clk = ~clk;

	function automatic syn_res_t syndrome_of(logic [WORD_W-1:0] e, logic [WORD_W-1:0] tgt);
		int unsigned rows;
		int unsigned cols;
		int unsigned cbits;
		logic [WORD_W-1:0] emask;
		logic [WORD_W-1:0] cmask;
		syn_res_t r;
		rows  = (m_rows > 64) ? 64 : m_rows;
		cols  = (m_cols > 64) ? 64 : m_cols;
		cbits = (m_cmp > 64) ? 64 : m_cmp;
		emask = (cols >= 64) ? '1 : ((64'd1 << cols) - 64'd1);
		cmask = (cbits >= 64) ? '1 : ((64'd1 << cbits) - 64'd1);
		r.syn = '0;
		for (int i = 0; i < rows; i++)
			r.syn[i] = ^(h_mat[i] & e & emask);
		r.match = (((r.syn ^ tgt) & cmask) == '0);
		r.zero  = ((r.syn & cmask) == '0);
		r.acc   = r.match | r.zero;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		int r;
		logic [WORD_W-1:0] one_hot;
		r = $urandom_range(0, 9);
		one_hot = 64'd1 << $urandom_range(0, 63);
		case (r)
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_reg_val();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 7'd0;
			1: return 7'd1;
			2, 3: return 7'd64;
			4: return CFG_W'($urandom_range(65, 127));
			default: return CFG_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic dir_ent_t ent_load(logic [ROW_IDX_W-1:0] i, logic [WORD_W-1:0] r);
		return '{ENT_WORD, CMD_LOAD, i, r, '0, '0, '0, '0, 1'b0, '0};
	endfunction

	function automatic dir_ent_t ent_check(logic [WORD_W-1:0] e, logic [WORD_W-1:0] t);
		return '{ENT_WORD, CMD_CHECK, '0, '0, e, t, '0, '0, 1'b0, '0};
	endfunction

	function automatic dir_ent_t ent_known(logic [WORD_W-1:0] e, logic [WORD_W-1:0] t,
		logic [WORD_W-1:0] s, logic m, logic z, logic a);
		return '{ENT_WORD, CMD_CHECK, '0, '0, e, t, '0, '0, 1'b1, '{s, m, z, a}};
	endfunction

	function automatic dir_ent_t ent_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_W-1:0] v);
		return '{ENT_REG, CMD_LOAD, '0, '0, '0, '0, i, v, 1'b0, '0};
	endfunction

	task automatic push_word(input dir_ent_t w);
		int gap;
		req_ch.valid           <= 1'b1;
		req_ch.cmd             <= w.cmd;
		req_ch.row_index       <= w.ridx;
		req_ch.row_bits        <= w.rbits;
		req_ch.error_vector    <= w.evec;
		req_ch.target_syndrome <= w.tgt;
		do @(posedge clk); while (!req_ch.ready);
		if (w.cmd == CMD_LOAD)
			h_mat[w.ridx] = w.rbits;
		else if (w.known)
			pending_syndromes = {pending_syndromes, w.res};
		else
			pending_syndromes = {pending_syndromes, syndrome_of(w.evec, w.tgt)};
		gap = req_stall_en ? gap_len() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (pending_syndromes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_NUM_ROWS:     m_rows = val;
			CFG_NUM_COLS:     m_cols = val;
			CFG_COMPARE_BITS: m_cmp  = val;
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		syn_res_t x;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_syndromes.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result with nothing pending: syn=%h m=%b z=%b a=%b",
						$realtime, rsp_ch.syndrome, rsp_ch.matches_target,
						rsp_ch.syndrome_zero, rsp_ch.accepted);
			end else begin
				x = pending_syndromes.pop_front();
				if (rsp_ch.syndrome !== x.syn || rsp_ch.matches_target !== x.match ||
					rsp_ch.syndrome_zero !== x.zero || rsp_ch.accepted !== x.acc) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: expected syn=%h m=%b z=%b a=%b, got syn=%h m=%b z=%b a=%b",
							$realtime, x.syn, x.match, x.zero, x.acc, rsp_ch.syndrome,
							rsp_ch.matches_target, rsp_ch.syndrome_zero, rsp_ch.accepted);
				end
			end
		end
	end

	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			n = rsp_stall_en ? gap_len() : 0;
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		dir_ent_t          dir_tab [$];
		dir_ent_t          w;
		syn_res_t          pr;
		logic [WORD_W-1:0] e;
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] s;
		int                pick;

		arst_n                 <= 1'b0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.index           <= '0;
		cfg_ch.data            <= '0;
		req_ch.valid           <= 1'b0;
		req_ch.cmd             <= CMD_LOAD;
		req_ch.row_index       <= '0;
		req_ch.row_bits        <= '0;
		req_ch.error_vector    <= '0;
		req_ch.target_syndrome <= '0;
		m_rows = 7'd64;
		m_cols = 7'd64;
		m_cmp  = 7'd64;
		foreach (h_mat[i])
			h_mat[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every row so no check ever reads an unwritten one
		for (int r = 0; r < 64; r++)
			push_word(ent_load(r[ROW_IDX_W-1:0], '1));

		dir_tab = {dir_tab, ent_known('0, '0, '0, 1'b1, 1'b1, 1'b1)};
		dir_tab = {dir_tab, ent_known('1, '1, '0, 1'b0, 1'b1, 1'b1)};
		dir_tab = {dir_tab, ent_known(64'd1, '1, '1, 1'b1, 1'b0, 1'b1)};
		dir_tab = {dir_tab, ent_known(64'd1, '0, '1, 1'b0, 1'b0, 1'b0)};
		dir_tab = {dir_tab, ent_load(6'd0, '0)};
		dir_tab = {dir_tab, ent_load(6'd63, 64'h8000_0000_0000_0001)};
		dir_tab = {dir_tab, ent_check(64'h8000_0000_0000_0000, '0)};
		dir_tab = {dir_tab, ent_check(64'h5555_5555_5555_5555, 64'h0123_4567_89ab_cdef)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_ROWS, 7'd1)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_COLS, 7'd1)};
		dir_tab = {dir_tab, ent_reg(CFG_COMPARE_BITS, 7'd0)};
		dir_tab = {dir_tab, ent_known('1, '1, '0, 1'b1, 1'b1, 1'b1)};
		dir_tab = {dir_tab, ent_load(6'd0, '1)};
		dir_tab = {dir_tab, ent_check('1, '0)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_ROWS, 7'd0)};
		dir_tab = {dir_tab, ent_reg(CFG_COMPARE_BITS, 7'd64)};
		dir_tab = {dir_tab, ent_known('1, '0, '0, 1'b1, 1'b1, 1'b1)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_ROWS, 7'd127)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_COLS, 7'd127)};
		dir_tab = {dir_tab, ent_reg(CFG_COMPARE_BITS, 7'd127)};
		dir_tab = {dir_tab, ent_reg(CFG_SPARE, 7'h7f)};
		dir_tab = {dir_tab, ent_check(64'd1, '1)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_COLS, 7'd0)};
		dir_tab = {dir_tab, ent_known('1, '1, '0, 1'b0, 1'b1, 1'b1)};
		dir_tab = {dir_tab, ent_reg(CFG_NUM_COLS, 7'd64)};
		dir_tab = {dir_tab, ent_reg(CFG_COMPARE_BITS, 7'd1)};
		dir_tab = {dir_tab, ent_check(64'h3, 64'h1)};
		dir_tab = {dir_tab, ent_reg(CFG_COMPARE_BITS, 7'd63)};
		dir_tab = {dir_tab, ent_load(6'd31, 64'hdead_beef_0bad_f00d)};
		dir_tab = {dir_tab, ent_check(64'hffff_0000_ffff_0000, '0)};
		dir_tab = {dir_tab, ent_check(64'h0000_0001_8000_0000, 64'h8000_0000_0000_0000)};

		foreach (dir_tab[k]) begin
			if (dir_tab[k].kind == ENT_REG) begin
				quiesce();
				write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
			end else begin
				push_word(dir_tab[k]);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiesce();
			write_reg(CFG_NUM_ROWS, rand_reg_val());
			write_reg(CFG_NUM_COLS, rand_reg_val());
			write_reg(CFG_COMPARE_BITS, rand_reg_val());
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_SPARE, CFG_W'($urandom));
			req_stall_en = ($urandom_range(0, 3) != 0);
			rsp_stall_en = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ($urandom_range(0, 99) < 25) begin
					w = ent_load(ROW_IDX_W'($urandom_range(0, 63)), rand_word());
				end else begin
					e = rand_word();
					pr = syndrome_of(e, '0);
					s = pr.syn;
					pick = $urandom_range(0, 9);
					case (pick)
						0, 1, 2, 3: t = s;
						4, 5: t = s ^ (64'd1 << $urandom_range(0, 63));
						6, 7: t = '0;
						default: t = {$urandom, $urandom};
					endcase
					w = ent_check(e, t);
				end
				push_word(w);
			end
		end

		quiesce();
		if (mismatch_cnt == 0 && pending_syndromes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
